// ===== rtl/scs_pkg.sv =====
// Shared constants, types and bit functions of the sorted code split search unit.
package scs_pkg;

    localparam int MAX_CODES = 4096;
    localparam int IDX_W     = 12;
    localparam int CODE_W    = 32;
    localparam int AXIS_W    = 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LAST,
        S_CHECK,
        S_SEARCH,
        S_AX_PREV,
        S_AX_CUR,
        S_AX_EVAL,
        S_OUT
    } state_t;

    // Sets every bit at and below the highest set bit.
    function automatic logic [CODE_W-1:0] smear_right(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

    // Marks the bit positions whose index modulo three equals sel.
    function automatic logic [CODE_W-1:0] axis_mask(input int sel);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++) begin
            m[i] = ((i % 3) == sel);
        end
        return m;
    endfunction

    localparam logic [CODE_W-1:0] AXIS1_MASK = axis_mask(1);
    localparam logic [CODE_W-1:0] AXIS2_MASK = axis_mask(2);

    // Index of the highest differing bit, modulo three; zero when nothing differs.
    function automatic logic [AXIS_W-1:0] axis_of(input logic [CODE_W-1:0] diff);
        logic [CODE_W-1:0] s;
        logic [CODE_W-1:0] top;
        s   = smear_right(diff);
        top = s & ~(s >> 1);
        return {|(top & AXIS2_MASK), |(top & AXIS1_MASK)};
    endfunction

endpackage

// ===== rtl/scs_if.sv =====
// Handshake interfaces of the command and response channels.
interface scs_cmd_if import scs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  write_address;
    logic [CODE_W-1:0] code_value;
    logic [IDX_W-1:0]  range_first;
    logic [IDX_W-1:0]  range_last;

    modport source (
        output valid, op, write_address, code_value, range_first, range_last,
        input  ready
    );
    modport sink (
        input  valid, op, write_address, code_value, range_first, range_last,
        output ready
    );
endinterface

interface scs_rsp_if import scs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  split_index;
    logic [AXIS_W-1:0] split_axis;

    modport source (
        output valid, split_index, split_axis,
        input  ready
    );
    modport sink (
        input  valid, split_index, split_axis,
        output ready
    );
endinterface

// ===== rtl/scs_ram.sv =====
// Generic single-port RAM with a registered read.
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/sorted_code_split_search_unit.sv =====
// Top level: code memory and split search sequencer.
//
//   channel | dir | payload                                                 | handshake
//   cmd     | in  | op, write_address, code_value, range_first, range_last  | valid/ready
//   rsp     | out | split_index, split_axis                                 | valid/ready
//
// A write transaction completes on acceptance and leaves the sequencer in S_IDLE. A query whose
// end codes differ makes one memory read per halving step, plus the two end reads and two axis
// reads, all through the single port of the code memory. S_AX_CUR and S_AX_EVAL are skipped
// when the split stays at first; equal end codes go from S_CHECK and a reversed range from S_IDLE
// straight to S_OUT. A response held on rsp stalls the sequencer in S_OUT. Queries are handled
// one at a time; a new transaction is taken while an earlier response still waits on rsp. Reset
// clears the sequencer and the response valid; memory contents are kept.
module sorted_code_split_search_unit import scs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    scs_cmd_if.sink   cmd,
    scs_rsp_if.source rsp
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [CODE_W-1:0] fcode_reg, fcode_next;
    logic [CODE_W-1:0] mask_reg, mask_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0]  split_reg, split_next;
    logic [IDX_W-1:0]  cand_reg, cand_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              more_reg, more_next;
    logic              pend_reg, pend_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]  rsp_index_reg, rsp_index_next;
    logic [AXIS_W-1:0] rsp_axis_reg, rsp_axis_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [CODE_W-1:0] ram_rdata;

    logic              accept;
    logic              out_load;
    logic              hit;
    logic [IDX_W-1:0]  split_cur;
    logic [IDX_W:0]    step_inc;
    logic [IDX_W-1:0]  step_half;
    logic [IDX_W:0]    cand_sum;
    logic              cand_ok;
    logic [IDX_W:0]    mid_sum;
    logic [CODE_W-1:0] end_diff;

    scs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_CODES)
    ) u_code_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.code_value),
        .rdata (ram_rdata)
    );

    assign cmd.ready       = (state_reg == S_IDLE);
    assign accept          = cmd.valid && cmd.ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.split_index = rsp_index_reg;
    assign rsp.split_axis  = rsp_axis_reg;
    assign out_load        = (state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready);

    // A candidate read issued last cycle is judged against the first code here.
    assign hit       = pend_reg && (((fcode_reg ^ ram_rdata) & mask_reg) == '0);
    assign split_cur = hit ? cand_reg : split_reg;
    assign step_inc  = {1'b0, step_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign step_half = step_inc[IDX_W:1];
    assign cand_sum  = {1'b0, split_cur} + {1'b0, step_half};
    assign cand_ok   = cand_sum < {1'b0, last_reg};
    assign mid_sum   = {1'b0, first_reg} + {1'b0, last_reg};
    assign end_diff  = fcode_reg ^ ram_rdata;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.op == OP_QUERY))
                begin
                    state_next = (cmd.range_last < cmd.range_first) ? S_OUT : S_RD_LAST;
                end
            end
            S_RD_LAST: state_next = S_CHECK;
            S_CHECK:   state_next = (ram_rdata == fcode_reg) ? S_OUT : S_SEARCH;
            S_SEARCH:
            begin
                if (!more_reg)
                begin
                    state_next = S_AX_PREV;
                end
            end
            S_AX_PREV: state_next = (split_reg > first_reg) ? S_AX_CUR : S_OUT;
            S_AX_CUR:  state_next = S_AX_EVAL;
            S_AX_EVAL: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we         = 1'b0;
        ram_addr       = split_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        fcode_next     = fcode_reg;
        mask_next      = mask_reg;
        prev_next      = prev_reg;
        split_next     = split_reg;
        cand_next      = cand_reg;
        step_next      = step_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        axis_next      = axis_reg;
        rsp_index_next = rsp_index_reg;
        rsp_axis_next  = rsp_axis_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr = (cmd.op == OP_WRITE) ? cmd.write_address : cmd.range_first;
                ram_we   = accept && (cmd.op == OP_WRITE);
                if (accept)
                begin
                    first_next = cmd.range_first;
                    last_next  = cmd.range_last;
                    split_next = cmd.range_first;
                    axis_next  = '0;
                end
            end
            S_RD_LAST:
            begin
                ram_addr   = last_reg;
                fcode_next = ram_rdata;
            end
            S_CHECK:
            begin
                if (ram_rdata == fcode_reg)
                begin
                    split_next = mid_sum[IDX_W:1];
                end
                else
                begin
                    // Bits at and above the highest differing bit of the two end codes.
                    mask_next  = ~(smear_right(end_diff) >> 1);
                    split_next = first_reg;
                    step_next  = last_reg - first_reg;
                    more_next  = 1'b1;
                    pend_next  = 1'b0;
                end
            end
            S_SEARCH:
            begin
                split_next = split_cur;
                pend_next  = 1'b0;
                if (more_reg)
                begin
                    ram_addr  = cand_sum[IDX_W-1:0];
                    cand_next = cand_sum[IDX_W-1:0];
                    step_next = step_half;
                    pend_next = cand_ok;
                    more_next = step_half > {{(IDX_W-1){1'b0}}, 1'b1};
                end
            end
            S_AX_PREV:
            begin
                ram_addr = split_reg - {{(IDX_W-1){1'b0}}, 1'b1};
            end
            S_AX_CUR:
            begin
                ram_addr  = split_reg;
                prev_next = ram_rdata;
            end
            S_AX_EVAL:
            begin
                axis_next = axis_of(prev_reg ^ ram_rdata);
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_index_next = split_reg;
                    rsp_axis_next  = axis_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        last_reg      <= last_next;
        fcode_reg     <= fcode_next;
        mask_reg      <= mask_next;
        prev_reg      <= prev_next;
        split_reg     <= split_next;
        cand_reg      <= cand_next;
        step_reg      <= step_next;
        axis_reg      <= axis_next;
        rsp_index_reg <= rsp_index_next;
        rsp_axis_reg  <= rsp_axis_next;
    end

    // The search never moves the split to or past the last index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (split_reg < last_reg))
        else $error("split reached the end of the range during search");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (step_reg != '0))
        else $error("search step collapsed to zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("response raised outside the result state");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_axis_reg != 2'd3))
        else $error("axis out of range");

endmodule

// ===== test/sorted_code_split_search_unit_test.sv =====
// Testbench of the sorted code split search unit: directed and random code loads and split queries.
module sorted_code_split_search_unit_test;
    import scs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [AXIS_W-1:0] axis;
    } split_t;

    logic clk = 1'b0;
    logic rst_n;

    scs_cmd_if cmd_ch ();
    scs_rsp_if rsp_ch ();

    sorted_code_split_search_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    logic [CODE_W-1:0] code_mem [MAX_CODES];
    split_t            split_results [$];
    int                errors = 0;
    int                items_sent = 0;
    int                cmd_idle_pct = 0;
    int                rsp_stall_pct = 0;
    int                long_hold_cycles = 0;

    function automatic int lead_zero_count(logic [CODE_W-1:0] v);
        int n;
        n = 0;
        for (int b = CODE_W - 1; b >= 0 && !v[b]; b--)
        begin
            n++;
        end
        return n;
    endfunction

    function automatic split_t predict_split(int unsigned first, int unsigned last);
        split_t            r;
        logic [CODE_W-1:0] fcode;
        logic [CODE_W-1:0] lcode;
        logic [CODE_W-1:0] diff;
        int unsigned       split;
        int unsigned       step;
        int unsigned       cand;
        int                common;
        split  = first;
        r.axis = '0;
        if (last >= first)
        begin
            fcode = code_mem[first];
            lcode = code_mem[last];
            if (fcode == lcode)
            begin
                split = (first + last) / 2;
            end
            else
            begin
                common = lead_zero_count(fcode ^ lcode);
                step   = last - first;
                do
                begin
                    step = (step + 1) / 2;
                    cand = split + step;
                    if (cand < last && common < lead_zero_count(fcode ^ code_mem[cand]))
                    begin
                        split = cand;
                    end
                end
                while (step > 1);
                if (split > first)
                begin
                    diff = code_mem[split - 1] ^ code_mem[split];
                    if (diff != '0)
                    begin
                        r.axis = AXIS_W'((CODE_W - 1 - lead_zero_count(diff)) % 3);
                    end
                end
            end
        end
        r.idx = IDX_W'(split);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    // Valid stays high on return so back-to-back items need no second assignment.
    task automatic send_item(op_t op, logic [IDX_W-1:0] addr, logic [CODE_W-1:0] code,
                             logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
        if ($urandom_range(0, 99) < cmd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.op            <= op;
        cmd_ch.write_address <= addr;
        cmd_ch.code_value    <= code;
        cmd_ch.range_first   <= first;
        cmd_ch.range_last    <= last;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        if (op == OP_WRITE)
        begin
            code_mem[addr] = code;
        end
        else
        begin
            split_results.push_back(predict_split(first, last));
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic put_code(int unsigned addr, logic [CODE_W-1:0] code);
        send_item(OP_WRITE, IDX_W'(addr), code,
                  IDX_W'($urandom_range(0, MAX_CODES - 1)),
                  IDX_W'($urandom_range(0, MAX_CODES - 1)));
    endtask

    task automatic ask_split(int unsigned first, int unsigned last);
        send_item(OP_QUERY, IDX_W'($urandom_range(0, MAX_CODES - 1)), $urandom,
                  IDX_W'(first), IDX_W'(last));
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // Loads an ascending run of codes; a narrow step keeps long shared prefixes.
    task automatic load_sorted_run(int unsigned base, int unsigned size);
        logic [CODE_W-1:0] code;
        logic [CODE_W:0]   next;
        int                min_shift;
        min_shift = $urandom_range(4, 28);
        code      = $urandom >> $urandom_range(0, 31);
        for (int unsigned i = 0; i < size; i++)
        begin
            put_code(base + i, code);
            next = {1'b0, code} + ({1'b0, $urandom} >> $urandom_range(min_shift, 32));
            code = next[CODE_W] ? '1 : next[CODE_W-1:0];
        end
    endtask

    task automatic test_directed_cases();
        cmd_idle_pct  = 20;
        rsp_stall_pct = 20;
        put_code(0, 32'h0000_0000);
        put_code(1, 32'h0000_0000);
        put_code(2, 32'h0000_0005);
        put_code(3, 32'h0000_0005);
        put_code(4, 32'h1234_5678);
        put_code(5, 32'h7FFF_FFFF);
        put_code(6, 32'h8000_0000);
        put_code(7, 32'hFFFF_FFFF);
        put_code(4092, 32'h4000_0000);
        put_code(4093, 32'h4000_0000);
        put_code(4094, 32'h4000_0001);
        put_code(4095, 32'hFFFF_FFFF);
        ask_split(0, 7);
        ask_split(0, 1);
        ask_split(2, 3);
        ask_split(4, 4);
        // Two-entry range splits at its first index, so the axis is zero.
        ask_split(1, 2);
        ask_split(0, 3);
        ask_split(5, 7);
        ask_split(4092, 4095);
        ask_split(4093, 4094);
        ask_split(4095, 4095);
        ask_split(4095, 0);
        ask_split(7, 0);
    endtask

    // The response side holds off while queries keep coming, so the unit fills and stalls.
    task automatic test_output_backpressure();
        int unsigned base;
        int unsigned first;
        base          = $urandom_range(0, MAX_CODES - 32);
        cmd_idle_pct  = 0;
        rsp_stall_pct = 0;
        load_sorted_run(base, 32);
        long_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 24; i++)
        begin
            first = base + $urandom_range(0, 31);
            ask_split(first, $urandom_range(first, base + 31));
        end
    endtask

    task automatic run_block();
        int unsigned size;
        int unsigned base;
        int unsigned first;
        int unsigned last;
        int          queries;
        size = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 24);
        base = $urandom_range(0, MAX_CODES - size);
        load_sorted_run(base, size);
        if ($urandom_range(0, 5) == 0)
        begin
            // Break the ordering inside the run and scribble somewhere else.
            put_code(base + $urandom_range(0, size - 1), $urandom);
            put_code($urandom_range(0, MAX_CODES - 1), $urandom);
        end
        queries = $urandom_range(2, 8);
        for (int i = 0; i < queries; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                first = $urandom_range(1, MAX_CODES - 1);
                ask_split(first, $urandom_range(0, first - 1));
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                ask_split(base, base + size - 1);
            end
            else
            begin
                first = base + $urandom_range(0, size - 1);
                last  = $urandom_range(first, base + size - 1);
                ask_split(first, last);
            end
        end
    endtask

    task automatic test_random_blocks();
        while (items_sent < RANDOM_ITEMS)
        begin
            cmd_idle_pct  = pick_pct();
            rsp_stall_pct = pick_pct();
            run_block();
        end
    endtask

    task automatic test_unthrottled_tail();
        cmd_idle_pct  = 0;
        rsp_stall_pct = 0;
        for (int i = 0; i < 6; i++)
        begin
            run_block();
        end
    endtask

    // Response ready: random stall bursts, plus the long hold when one is requested.
    initial
    begin : drive_ready
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                stall_left       = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < rsp_stall_pct)
            begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        split_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (split_results.size() == 0)
            begin
                $display("%0t: unexpected result, split_index %0d split_axis %0d",
                         $time, rsp_ch.split_index, rsp_ch.split_axis);
                errors++;
            end
            else
            begin
                want = split_results.pop_front();
                if (rsp_ch.split_index !== want.idx)
                begin
                    $display("%0t: split_index expected %0d, actual %0d",
                             $time, want.idx, rsp_ch.split_index);
                    errors++;
                end
                if (rsp_ch.split_axis !== want.axis)
                begin
                    $display("%0t: split_axis expected %0d, actual %0d",
                             $time, want.axis, rsp_ch.split_axis);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.op            = OP_WRITE;
        cmd_ch.write_address = '0;
        cmd_ch.code_value    = '0;
        cmd_ch.range_first   = '0;
        cmd_ch.range_last    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_blocks();
        test_unthrottled_tail();

        cmd_ch.valid <= 1'b0;
        while (split_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && split_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
